// File: sv/scfr_pkg.sv
package scfr_pkg;

	localparam int MAX_PAYLOAD_DEF = 128;

	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_M = 8'h4D;
	localparam logic [7:0] CH_LT = 8'h3C;
	localparam logic [7:0] CH_HASH = 8'h23;
	localparam logic [7:0] REBOOT_RESET = 8'h52;

	typedef enum logic [2:0] {
		PH_HUNT,
		PH_DOLLAR,
		PH_M,
		PH_ARROW,
		PH_CMD,
		PH_PAYLOAD
	} phase_t;

	typedef enum logic [1:0] {
		EV_PAYLOAD,
		EV_GOOD,
		EV_BAD,
		EV_REBOOT
	} event_t;

	typedef struct packed {
		event_t kind;
		logic [7:0] command;
		logic [7:0] value;
		logic [6:0] index;
		logic [7:0] length;
	} result_t;

endpackage

// File: sv/scfr_parser.sv
module scfr_parser #(
	parameter int MAX_PAYLOAD = scfr_pkg::MAX_PAYLOAD_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic step,
	input  logic [7:0] rx_byte,
	input  logic is_armed,
	input  logic [7:0] reboot_byte,
	output logic res_valid,
	output scfr_pkg::result_t res
);
	import scfr_pkg::*;

	localparam logic [7:0] MaxLen = 8'(MAX_PAYLOAD);

	phase_t phase_q, phase_d;
	logic [7:0] xor_q, xor_d;
	logic [7:0] len_q, len_d;
	logic [7:0] taken_q, taken_d;
	logic [7:0] cmd_q, cmd_d;

	always_comb begin
		phase_d = phase_q;
		xor_d = xor_q;
		len_d = len_q;
		taken_d = taken_q;
		cmd_d = cmd_q;
		case (phase_q)
			PH_DOLLAR: phase_d = (rx_byte == CH_M) ? PH_M : PH_HUNT;
			PH_M: phase_d = (rx_byte == CH_LT) ? PH_ARROW : PH_HUNT;
			PH_ARROW: begin
				if (rx_byte > MaxLen) begin
					phase_d = PH_HUNT;
				end else begin
					len_d = rx_byte;
					taken_d = '0;
					xor_d = rx_byte;
					phase_d = PH_CMD;
				end
			end
			PH_CMD: begin
				cmd_d = rx_byte;
				xor_d = xor_q ^ rx_byte;
				phase_d = PH_PAYLOAD;
			end
			PH_PAYLOAD: begin
				if (taken_q < len_q) begin
					xor_d = xor_q ^ rx_byte;
					taken_d = taken_q + 8'd1;
				end else begin
					phase_d = PH_HUNT;
				end
			end
			default: phase_d = (rx_byte == CH_DOLLAR) ? PH_DOLLAR : PH_HUNT;
		endcase
	end

	always_comb begin
		res_valid = 1'b0;
		res = '{kind: EV_PAYLOAD, command: '0, value: '0, index: '0, length: '0};
		case (phase_q)
			PH_DOLLAR, PH_M, PH_ARROW, PH_CMD: res_valid = 1'b0;
			PH_PAYLOAD: begin
				res_valid = 1'b1;
				res.command = cmd_q;
				res.length = len_q;
				if (taken_q < len_q) begin
					res.kind = EV_PAYLOAD;
					res.value = rx_byte;
					res.index = taken_q[6:0];
				end else begin
					res.kind = (xor_q == rx_byte) ? EV_GOOD : EV_BAD;
				end
			end
			default: begin
				if (rx_byte != CH_DOLLAR && !is_armed && rx_byte != CH_HASH
						&& rx_byte == reboot_byte) begin
					res_valid = 1'b1;
					res.kind = EV_REBOOT;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			xor_q <= '0;
			len_q <= '0;
			taken_q <= '0;
			cmd_q <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			xor_q <= xor_d;
			len_q <= len_d;
			taken_q <= taken_d;
			cmd_q <= cmd_d;
		end
	end

endmodule

// File: sv/serial_command_frame_receiver.sv
// channel | handshake               | payload
// --------+-------------------------+----------------------------------------------
// in      | in_valid / in_stall     | rx_byte, is_armed
// out     | out_valid / out_stall   | event_kind, frame_command, payload_byte,
//         |                         | payload_index, frame_length
// cfg     | cfg_valid / cfg_ready   | reboot_byte
// One item per cycle unless stalled: input register, one parser update, output register.
// A result goes from the input register through the parser into the output register.
// Reset clears parser state and valid flags; reboot byte resets to 'R'.
// An item waits in the input register only while the output register is full and stalled.
module serial_command_frame_receiver #(
	parameter int MAX_PAYLOAD = scfr_pkg::MAX_PAYLOAD_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic [7:0] rx_byte,
	input  logic is_armed,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [7:0] reboot_byte,
	output logic out_valid,
	input  logic out_stall,
	output logic [1:0] event_kind,
	output logic [7:0] frame_command,
	output logic [7:0] payload_byte,
	output logic [6:0] payload_index,
	output logic [7:0] frame_length
);
	import scfr_pkg::*;

	logic valid_s1;
	logic [7:0] byte_s1;
	logic armed_s1;
	logic [7:0] reboot_q;
	logic go;
	logic res_valid;
	result_t res;
	logic valid_s2;
	result_t res_s2;

	assign go = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !go;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reboot_q <= REBOOT_RESET;
		end else if (cfg_valid) begin
			reboot_q <= reboot_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= rx_byte;
			armed_s1 <= is_armed;
		end
	end

	scfr_parser #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) u_parser (
		.clk(clk),
		.arst_n(arst_n),
		.step(go),
		.rx_byte(byte_s1),
		.is_armed(armed_s1),
		.reboot_byte(reboot_q),
		.res_valid(res_valid),
		.res(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (go && res_valid) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go && res_valid) begin
			res_s2 <= res;
		end
	end

	assign out_valid = valid_s2;
	assign event_kind = res_s2.kind;
	assign frame_command = res_s2.command;
	assign payload_byte = res_s2.value;
	assign payload_index = res_s2.index;
	assign frame_length = res_s2.length;

endmodule

// File: bench/serial_command_frame_receiver_tb.sv
module serial_command_frame_receiver_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import scfr_pkg::*;

	localparam int PAYLOAD_MAX = MAX_PAYLOAD_DEF;
	localparam int CYCLE_LIMIT = 200000;

	typedef struct packed {
		logic [7:0] value;
		logic armed;
	} rx_item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [7:0] rx_byte = 8'h00;
	logic is_armed = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [7:0] reboot_byte = 8'h00;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [1:0] event_kind;
	logic [7:0] frame_command;
	logic [7:0] payload_byte;
	logic [6:0] payload_index;
	logic [7:0] frame_length;

	serial_command_frame_receiver #(
		.MAX_PAYLOAD(PAYLOAD_MAX)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.rx_byte(rx_byte),
		.is_armed(is_armed),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.reboot_byte(reboot_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.event_kind(event_kind),
		.frame_command(frame_command),
		.payload_byte(payload_byte),
		.payload_index(payload_index),
		.frame_length(frame_length)
	);

	always #1 clk = ~clk;

	// byte stream waiting to be sent, and events the parser should produce
	rx_item_t rx_pending[$];
	result_t expected_events[$];
	int queued_count = 0;
	int taken_count = 0;
	int mismatches = 0;
	int cycles = 0;

	// parser mirror
	phase_t frame_phase;
	logic [7:0] xor_sum;
	logic [7:0] decl_len;
	logic [7:0] bytes_seen;
	logic [7:0] cmd_code;
	logic [7:0] reboot_cfg;

	task automatic parse_byte(input logic [7:0] c, input logic armed);
		result_t ev;
		ev = '0;
		case (frame_phase)
			PH_DOLLAR: frame_phase = (c == CH_M) ? PH_M : PH_HUNT;
			PH_M: frame_phase = (c == CH_LT) ? PH_ARROW : PH_HUNT;
			PH_ARROW: begin
				if (c > PAYLOAD_MAX) begin
					frame_phase = PH_HUNT;
				end else begin
					decl_len = c;
					bytes_seen = 8'h00;
					xor_sum = c;
					frame_phase = PH_CMD;
				end
			end
			PH_CMD: begin
				cmd_code = c;
				xor_sum ^= c;
				frame_phase = PH_PAYLOAD;
			end
			PH_PAYLOAD: begin
				ev.command = cmd_code;
				ev.length = decl_len;
				if (bytes_seen < decl_len) begin
					ev.kind = EV_PAYLOAD;
					ev.value = c;
					ev.index = bytes_seen[6:0];
					xor_sum ^= c;
					bytes_seen++;
				end else begin
					ev.kind = (xor_sum == c) ? EV_GOOD : EV_BAD;
					frame_phase = PH_HUNT;
				end
				expected_events.push_back(ev);
			end
			default: begin
				if (c == CH_DOLLAR) begin
					frame_phase = PH_DOLLAR;
				end else begin
					frame_phase = PH_HUNT;
					if (!armed && c != CH_HASH && c == reboot_cfg) begin
						ev.kind = EV_REBOOT;
						expected_events.push_back(ev);
					end
				end
			end
		endcase
	endtask

	task automatic report_mismatch(input string msg);
		$display("%0t ns  mismatch: %s", $time, msg);
		mismatches++;
	endtask

	task automatic check_event();
		result_t want;
		if (expected_events.size() == 0) begin
			report_mismatch($sformatf("event kind %0d with nothing expected", event_kind));
		end else begin
			want = expected_events.pop_front();
			if (event_kind !== want.kind)
				report_mismatch($sformatf("event_kind %0d, want %0d", event_kind, want.kind));
			if (frame_command !== want.command)
				report_mismatch($sformatf("frame_command %h, want %h",
					frame_command, want.command));
			if (payload_byte !== want.value)
				report_mismatch($sformatf("payload_byte %h, want %h", payload_byte, want.value));
			if (payload_index !== want.index)
				report_mismatch($sformatf("payload_index %0d, want %0d",
					payload_index, want.index));
			if (frame_length !== want.length)
				report_mismatch($sformatf("frame_length %0d, want %0d",
					frame_length, want.length));
		end
	endtask

	// input side: bursts of items with random gaps, now and then a full drain
	rx_item_t next_item;
	logic in_taken = 1'b0;
	int burst_left = 0;
	int gap_left = 0;
	bit hold_for_drain = 1'b0;

	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_taken)) begin
			if (hold_for_drain) begin
				if (expected_events.size() == 0)
					hold_for_drain = 1'b0;
				in_valid <= 1'b0;
			end else if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (rx_pending.size() > 0) begin
				next_item = rx_pending.pop_front();
				in_valid <= 1'b1;
				rx_byte <= next_item.value;
				is_armed <= next_item.armed;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 48);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
					hold_for_drain = ($urandom_range(0, 19) == 0);
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// output side stall pattern, in one of four modes chosen at random
	int stall_tick = 0;
	int stall_mode = 0;

	always @(negedge clk) begin
		stall_tick++;
		if (stall_tick % 64 == 0)
			stall_mode = $urandom_range(0, 3);
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 1) == 1);
			2: out_stall <= (stall_tick % 5) < 2;
			default: out_stall <= (stall_tick % 16) >= 8;
		endcase
	end

	always @(posedge clk) begin
		in_taken <= arst_n && in_valid && !in_stall;
		if (arst_n && in_valid && !in_stall) begin
			taken_count++;
			parse_byte(rx_byte, is_armed);
		end
		if (arst_n && out_valid && !out_stall)
			check_event();
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic add_byte(input logic [7:0] v, input logic armed);
		rx_item_t it;
		it.value = v;
		it.armed = armed;
		rx_pending.push_back(it);
		queued_count++;
	endtask

	function automatic logic rand_armed();
		return ($urandom_range(0, 3) == 0);
	endfunction

	task automatic add_frame(input int len, input logic [7:0] cmd, input bit corrupt);
		logic [7:0] sum;
		logic [7:0] b;
		add_byte(CH_DOLLAR, rand_armed());
		add_byte(CH_M, rand_armed());
		add_byte(CH_LT, rand_armed());
		add_byte(len[7:0], rand_armed());
		add_byte(cmd, rand_armed());
		sum = len[7:0] ^ cmd;
		for (int i = 0; i < len; i++) begin
			b = 8'($urandom);
			sum ^= b;
			add_byte(b, rand_armed());
		end
		if (corrupt)
			sum ^= 8'($urandom_range(1, 255));
		add_byte(sum, rand_armed());
	endtask

	task automatic add_random(input int count);
		int stop_at;
		int sel;
		int len;
		stop_at = queued_count + count;
		while (queued_count < stop_at) begin
			sel = $urandom_range(0, 99);
			if (sel < 70) begin
				case ($urandom_range(0, 49))
					0: len = PAYLOAD_MAX;
					1: len = PAYLOAD_MAX - 1;
					2: len = $urandom_range(9, PAYLOAD_MAX);
					default: len = $urandom_range(0, 8);
				endcase
				add_frame(len, 8'($urandom), $urandom_range(0, 4) == 0);
			end else if (sel < 85) begin
				repeat ($urandom_range(1, 6)) begin
					case ($urandom_range(0, 4))
						0: add_byte(reboot_cfg, rand_armed());
						1: add_byte(CH_HASH, rand_armed());
						2: add_byte(CH_DOLLAR, rand_armed());
						default: add_byte(8'($urandom), rand_armed());
					endcase
				end
			end else begin
				add_byte(CH_DOLLAR, rand_armed());
				case ($urandom_range(0, 3))
					0: add_byte(8'($urandom), rand_armed());
					1: begin
						add_byte(CH_M, rand_armed());
						add_byte(8'($urandom), rand_armed());
					end
					2: begin
						add_byte(CH_M, rand_armed());
						add_byte(CH_LT, rand_armed());
						add_byte(8'($urandom_range(PAYLOAD_MAX + 1, 255)), rand_armed());
					end
					default: add_byte(CH_DOLLAR, rand_armed());
				endcase
			end
		end
	endtask

	task automatic wait_idle();
		do
			@(negedge clk);
		while (taken_count != queued_count || expected_events.size() != 0);
		repeat (6) @(negedge clk);
	endtask

	task automatic write_reboot(input logic [7:0] v);
		wait_idle();
		cfg_valid <= 1'b1;
		reboot_byte <= v;
		do
			@(posedge clk);
		while (!cfg_ready);
		reboot_cfg = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	logic [7:0] reboot_values[6];

	initial begin
		frame_phase = PH_HUNT;
		xor_sum = 8'h00;
		decl_len = 8'h00;
		bytes_seen = 8'h00;
		cmd_code = 8'h00;
		reboot_cfg = REBOOT_RESET;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		// directed: reboot armed and disarmed, header errors, length limits, checksums
		add_byte(REBOOT_RESET, 1'b0);
		add_byte(REBOOT_RESET, 1'b1);
		add_byte(CH_DOLLAR, 1'b0);
		add_byte(CH_DOLLAR, 1'b0);
		add_byte(CH_M, 1'b0);
		add_byte(CH_LT, 1'b0);
		add_byte(CH_DOLLAR, 1'b0);
		add_byte(CH_M, 1'b0);
		add_byte(8'h58, 1'b0);
		add_byte(CH_DOLLAR, 1'b1);
		add_byte(CH_M, 1'b1);
		add_byte(CH_LT, 1'b1);
		add_byte(8'(PAYLOAD_MAX + 1), 1'b1);
		add_frame(0, 8'hFF, 1'b0);
		add_frame(2, 8'h00, 1'b1);
		add_random(300);

		reboot_values = '{8'h00, 8'hFF, CH_HASH, CH_DOLLAR, 8'h00, CH_M};
		reboot_values[4] = 8'($urandom);
		foreach (reboot_values[i]) begin
			write_reboot(reboot_values[i]);
			add_byte(reboot_values[i], 1'b0);
			add_random(220);
		end

		wait_idle();
		if (mismatches == 0 && expected_events.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

// File: sim.f
sv/scfr_pkg.sv
sv/scfr_parser.sv
sv/serial_command_frame_receiver.sv
bench/serial_command_frame_receiver_tb.sv
